>>> sv/qfs_pkg.sv
// shared types, constants and fixed-point helpers for the quaternion slerp block
package qfs_pkg;

    localparam int COMP_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int IFRAC      = 26;
    localparam int BLEND_BITS = 17;
    localparam int QDEPTH     = 4;
    localparam int NSTAGE     = 25;

    typedef logic signed [31:0] t_v;

    localparam t_v VMAX   = 32'sh7fff_ffff;
    localparam t_v ONE_Q  = 32'sh0400_0000;
    localparam t_v HALF_Q = 32'sh0200_0000;
    localparam t_v K_109  = 32'sd73148662;
    localparam t_v K_0476 = 32'sd31979857;
    localparam t_v K_0090 = 32'sd6062085;
    localparam t_v K_15   = 32'sd100663296;
    localparam t_v K_S0   = 32'sd2959;
    localparam t_v K_S1   = -32'sd106522;
    localparam t_v K_S2   = 32'sd2236962;
    localparam t_v K_S3   = -32'sd22369621;

    localparam logic [BLEND_BITS-1:0] BLEND_ONE = 17'd65536;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] a_x;
        logic signed [COMP_BITS-1:0] a_y;
        logic signed [COMP_BITS-1:0] a_z;
        logic signed [COMP_BITS-1:0] a_w;
        logic signed [COMP_BITS-1:0] b_x;
        logic signed [COMP_BITS-1:0] b_y;
        logic signed [COMP_BITS-1:0] b_z;
        logic signed [COMP_BITS-1:0] b_w;
        logic [BLEND_BITS-1:0]       blend;
    } t_in;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] out_x;
        logic signed [COMP_BITS-1:0] out_y;
        logic signed [COMP_BITS-1:0] out_z;
        logic signed [COMP_BITS-1:0] out_w;
    } t_out;

    // working set carried down the back pipeline
    typedef struct packed {
        logic     byp;
        logic     flip;
        t_v [3:0] raw;
        t_v [3:0] a;
        t_v [3:0] b;
        t_v [3:0] q;
        t_v       acc;
        t_v       halfy;
        t_v       h;
        t_v       tmp;
        t_v       vers;
        t_v       r2;
        t_v       f1;
        t_v       f2a;
        t_v       f2b;
        t_v       sa;
        t_v       sb;
        t_v       ra;
        t_v       rb;
        t_v       wa;
        t_v       wb;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // saturating add
    function automatic t_v add(input t_v a, input t_v b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({b[31], b});
        if (s > 33'sd2147483647) return VMAX;
        if (s < -33'sd2147483647) return -VMAX;
        return s[31:0];
    endfunction

    // saturating subtract
    function automatic t_v sub(input t_v a, input t_v b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) - $signed({b[31], b});
        if (s > 33'sd2147483647) return VMAX;
        if (s < -33'sd2147483647) return -VMAX;
        return s[31:0];
    endfunction

    // magnitude after clipping to the symmetric range
    function automatic logic [30:0] mag(input t_v a);
        logic [31:0] n;
        n = -a;
        if (a == 32'sh8000_0000) return 31'h7fff_ffff;
        return a[31] ? n[30:0] : a[30:0];
    endfunction

    // Q.26 product, rounded half away from zero, saturated
    function automatic t_v fmul(input t_v a, input t_v b);
        logic [61:0] p;
        logic [35:0] r;
        logic [31:0] m;
        logic        neg;
        neg = a[31] ^ b[31];
        p   = mag(a) * mag(b);
        r   = 36'((p + 62'(33554432)) >> IFRAC);
        if (r > 36'(VMAX)) r = 36'(VMAX);
        m = r[31:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

>>> sv/qfs_queue.sv
// short register queue between the front and back parts
module qfs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qfs_pkg::t_work    i_item,
    input  logic              i_pop,
    output qfs_pkg::t_work    o_item,
    output qfs_pkg::t_qstat   o_stat
);

    localparam int DEPTH = qfs_pkg::QDEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    qfs_pkg::t_work r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  n_cnt;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr  = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd  = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

>>> sv/qfs_front.sv
// front part: takes beats, sorts out the special cases, scales the inputs
module qfs_front #(
    parameter int FRAC_BITS = qfs_pkg::FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  qfs_pkg::t_in     i_data,
    output logic             o_push,
    output qfs_pkg::t_work   o_item,
    input  qfs_pkg::t_qstat  i_qst
);

    localparam int CB  = qfs_pkg::COMP_BITS;
    localparam int LSH = (FRAC_BITS <= qfs_pkg::IFRAC) ? qfs_pkg::IFRAC - FRAC_BITS : 0;
    localparam int RSH = (FRAC_BITS > qfs_pkg::IFRAC) ? FRAC_BITS - qfs_pkg::IFRAC : 1;

    // component to Q.26, saturated
    function automatic qfs_pkg::t_v to_q26(input logic signed [CB-1:0] c);
        logic signed [63:0] w;
        logic [63:0]        m;
        if (FRAC_BITS <= qfs_pkg::IFRAC) begin
            w = 64'(c) <<< LSH;
        end else begin
            m = c[CB-1] ? 64'(-64'(c)) : 64'(c);
            m = (m + (64'd1 << (RSH - 1))) >> RSH;
            w = c[CB-1] ? -$signed(m) : $signed(m);
        end
        if (w > 64'sd2147483647) w = 64'sd2147483647;
        if (w < -64'sd2147483647) w = -64'sd2147483647;
        return w[31:0];
    endfunction

    logic                        r_fv;
    qfs_pkg::t_work              r_f;
    qfs_pkg::t_work              n_item;
    logic                        accept;
    logic                        push;
    logic                        same;
    logic                        pick_a;
    logic [qfs_pkg::BLEND_BITS-1:0] bl;
    logic signed [CB-1:0]        ca [4];
    logic signed [CB-1:0]        cb [4];
    qfs_pkg::t_v                 d;
    qfs_pkg::t_v                 u;
    qfs_pkg::t_v                 u2;

    assign ca[0] = i_data.a_x;
    assign ca[1] = i_data.a_y;
    assign ca[2] = i_data.a_z;
    assign ca[3] = i_data.a_w;
    assign cb[0] = i_data.b_x;
    assign cb[1] = i_data.b_y;
    assign cb[2] = i_data.b_z;
    assign cb[3] = i_data.b_w;

    // classify and prepare the beat
    always_comb begin
        bl     = (i_data.blend > qfs_pkg::BLEND_ONE) ? qfs_pkg::BLEND_ONE : i_data.blend;
        same   = (ca[0] == cb[0]) && (ca[1] == cb[1]) && (ca[2] == cb[2]) && (ca[3] == cb[3]);
        pick_a = (bl == '0) || same;
        d      = $signed({5'd0, bl, 10'd0}) - qfs_pkg::HALF_Q;
        u      = d[31] ? -d : d;
        u2     = u + u;
        n_item = '0;
        n_item.byp = pick_a || (bl == qfs_pkg::BLEND_ONE);
        for (int i = 0; i < 4; i++) begin
            n_item.raw[i] = pick_a ? 32'(ca[i]) : 32'(cb[i]);
            n_item.a[i]   = to_q26(ca[i]);
            n_item.b[i]   = to_q26(cb[i]);
        end
        n_item.f2a = u - d;
        n_item.f2b = d + u;
        n_item.f1  = qfs_pkg::ONE_Q - u2;
        n_item.sa  = qfs_pkg::ONE_Q - u2;
        n_item.sb  = u2;
    end

    // handshake
    assign push    = r_fv && !i_qst.full;
    assign o_stall = r_fv && i_qst.full;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= accept || (r_fv && !push);
        end
        if (accept) begin
            r_f <= n_item;
        end
    end

    assign o_push = push;
    assign o_item = r_f;

endmodule

>>> sv/qfs_back.sv
// back part: pipelined weight series, blend and renormalize
module qfs_back #(
    parameter int FRAC_BITS = qfs_pkg::FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qfs_pkg::t_work   i_item,
    input  qfs_pkg::t_qstat  i_qst,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output qfs_pkg::t_out    o_data
);

    localparam int CB  = qfs_pkg::COMP_BITS;
    localparam int NS  = qfs_pkg::NSTAGE;
    localparam int RSH = (FRAC_BITS < qfs_pkg::IFRAC) ? qfs_pkg::IFRAC - FRAC_BITS : 1;
    localparam int LSH = (FRAC_BITS > qfs_pkg::IFRAC) ? FRAC_BITS - qfs_pkg::IFRAC : 0;
    localparam logic signed [63:0] HI = (64'sd1 <<< (CB - 1)) - 64'sd1;
    localparam logic signed [63:0] LO = -HI - 64'sd1;

    // Q.26 back to the component format, saturated
    function automatic logic [CB-1:0] pack(input qfs_pkg::t_v v);
        logic signed [63:0] w;
        logic [63:0]        m;
        if (FRAC_BITS < qfs_pkg::IFRAC) begin
            m = v[31] ? 64'(-64'(v)) : 64'(v);
            m = (m + (64'd1 << (RSH - 1))) >> RSH;
            w = v[31] ? -$signed(m) : $signed(m);
        end else begin
            w = 64'(v) <<< LSH;
        end
        if (w > HI) w = HI;
        if (w < LO) w = LO;
        return w[CB-1:0];
    endfunction

    // work done by each pipeline stage
    function automatic qfs_pkg::t_work step(input int k, input qfs_pkg::t_work s);
        qfs_pkg::t_work r;
        qfs_pkg::t_v    x;
        r = s;
        x = '0;
        case (k)
            0: begin
                for (int i = 0; i < 4; i++) r.q[i] = qfs_pkg::fmul(s.a[i], s.b[i]);
                r.sa = qfs_pkg::fmul(s.sa, s.sa);
                r.sb = qfs_pkg::fmul(s.sb, s.sb);
            end
            1: begin
                x = qfs_pkg::add(qfs_pkg::add('0, s.q[0]), s.q[1]);
                x = qfs_pkg::add(qfs_pkg::add(x, s.q[2]), s.q[3]);
                r.acc   = x;
                r.flip  = x[31];
                r.halfy = qfs_pkg::add(qfs_pkg::ONE_Q, x[31] ? -x : x);
            end
            2: r.tmp = qfs_pkg::fmul(qfs_pkg::K_0090, s.halfy);
            3: r.tmp = qfs_pkg::fmul(qfs_pkg::sub(qfs_pkg::K_0476, s.tmp), s.halfy);
            4: begin
                r.h   = qfs_pkg::sub(qfs_pkg::K_109, s.tmp);
                r.tmp = qfs_pkg::fmul(s.halfy, r.h);
            end
            5: r.tmp = qfs_pkg::fmul(s.tmp, s.h);
            6: r.h = qfs_pkg::fmul(s.h, qfs_pkg::sub(qfs_pkg::K_15, s.tmp));
            7: r.tmp = qfs_pkg::fmul(s.halfy, s.h);
            8: begin
                r.vers = qfs_pkg::sub(qfs_pkg::ONE_Q, s.tmp);
                r.r2   = qfs_pkg::fmul(qfs_pkg::K_S0, r.vers);
            end
            9: begin
                r.ra = qfs_pkg::fmul(qfs_pkg::sub(s.sa, 32'sd16 <<< qfs_pkg::IFRAC), s.r2);
                r.rb = qfs_pkg::fmul(qfs_pkg::sub(s.sb, 32'sd16 <<< qfs_pkg::IFRAC), s.r2);
            end
            10: begin
                r.ra = qfs_pkg::fmul(qfs_pkg::add(qfs_pkg::K_S1, s.ra),
                                     qfs_pkg::sub(s.sa, 32'sd9 <<< qfs_pkg::IFRAC));
                r.rb = qfs_pkg::fmul(qfs_pkg::add(qfs_pkg::K_S1, s.rb),
                                     qfs_pkg::sub(s.sb, 32'sd9 <<< qfs_pkg::IFRAC));
            end
            11, 13, 15: begin
                r.ra = qfs_pkg::fmul(s.ra, s.vers);
                r.rb = qfs_pkg::fmul(s.rb, s.vers);
            end
            12: begin
                r.ra = qfs_pkg::fmul(qfs_pkg::add(qfs_pkg::K_S2, s.ra),
                                     qfs_pkg::sub(s.sa, 32'sd4 <<< qfs_pkg::IFRAC));
                r.rb = qfs_pkg::fmul(qfs_pkg::add(qfs_pkg::K_S2, s.rb),
                                     qfs_pkg::sub(s.sb, 32'sd4 <<< qfs_pkg::IFRAC));
            end
            14: begin
                r.ra = qfs_pkg::fmul(qfs_pkg::add(qfs_pkg::K_S3, s.ra),
                                     qfs_pkg::sub(s.sa, qfs_pkg::ONE_Q));
                r.rb = qfs_pkg::fmul(qfs_pkg::add(qfs_pkg::K_S3, s.rb),
                                     qfs_pkg::sub(s.sb, qfs_pkg::ONE_Q));
            end
            16: begin
                x     = qfs_pkg::add(qfs_pkg::ONE_Q, s.rb);
                r.tmp = qfs_pkg::fmul(qfs_pkg::add(qfs_pkg::ONE_Q, s.ra), s.h);
                r.f2a = qfs_pkg::fmul(s.f2a, x);
                r.f2b = qfs_pkg::fmul(s.f2b, x);
            end
            17: r.f1 = qfs_pkg::fmul(s.f1, s.tmp);
            18: begin
                x    = qfs_pkg::add(s.f1, s.f2a);
                r.wa = s.flip ? -x : x;
                r.wb = qfs_pkg::add(s.f1, s.f2b);
            end
            19: begin
                for (int i = 0; i < 4; i++) begin
                    r.a[i] = qfs_pkg::fmul(s.wa, s.a[i]);
                    r.b[i] = qfs_pkg::fmul(s.wb, s.b[i]);
                end
            end
            20: for (int i = 0; i < 4; i++) r.q[i] = qfs_pkg::add(s.a[i], s.b[i]);
            21: for (int i = 0; i < 4; i++) r.a[i] = qfs_pkg::fmul(s.q[i], s.q[i]);
            22: begin
                x = qfs_pkg::add(qfs_pkg::add('0, s.a[0]), s.a[1]);
                r.acc = qfs_pkg::add(qfs_pkg::add(x, s.a[2]), s.a[3]);
            end
            23: r.tmp = qfs_pkg::fmul(qfs_pkg::HALF_Q, s.acc);
            24: begin
                x = qfs_pkg::sub(qfs_pkg::K_15, s.tmp);
                for (int i = 0; i < 4; i++) r.q[i] = qfs_pkg::fmul(s.q[i], x);
            end
            default: r = s;
        endcase
        return r;
    endfunction

    qfs_pkg::t_work r_st [NS];
    logic           r_sv [NS];
    qfs_pkg::t_work w_in [NS];
    logic           w_iv [NS];
    logic           r_ov;
    qfs_pkg::t_out  r_out;
    qfs_pkg::t_out  n_out;
    logic           en;

    // whole pipeline moves unless a held result is stalled
    assign en    = !r_ov || !i_stall;
    assign o_pop = en && !i_qst.empty;

    assign w_in[0] = i_item;
    assign w_iv[0] = !i_qst.empty;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        if (g > 0) begin : g_link
            assign w_in[g] = r_st[g-1];
            assign w_iv[g] = r_sv[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[g] <= 1'b0;
            end else if (en) begin
                r_sv[g] <= w_iv[g];
            end
            if (en) begin
                r_st[g] <= step(g, w_in[g]);
            end
        end
    end

    // result formation
    always_comb begin
        if (r_st[NS-1].byp) begin
            n_out.out_x = r_st[NS-1].raw[0][CB-1:0];
            n_out.out_y = r_st[NS-1].raw[1][CB-1:0];
            n_out.out_z = r_st[NS-1].raw[2][CB-1:0];
            n_out.out_w = r_st[NS-1].raw[3][CB-1:0];
        end else begin
            n_out.out_x = pack(r_st[NS-1].q[0]);
            n_out.out_y = pack(r_st[NS-1].q[1]);
            n_out.out_z = pack(r_st[NS-1].q[2]);
            n_out.out_w = pack(r_st[NS-1].q[3]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_sv[NS-1];
        end
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

>>> sv/quaternion_fast_slerp.sv
// Fast quaternion slerp, top level.
// Input channel: i_valid / o_stall with i_data carrying quaternions a and b
// (signed Q2.14) and blend (Q1.16, 65536 is one). A beat is taken at a rising
// edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_data holding the interpolated,
// renormalized and saturated quaternion; one result beat per input beat,
// in order.
// A beat passes one front register, the queue write, 25 back pipeline stages
// and the output register.
// Throughput is one beat per cycle while the output is not stalled; each back
// stage holds at most one 32x32 product level. Blend zero, equal inputs and
// blend one pass straight through the same pipeline, so order is kept.
// A stalled output holds o_data and freezes the back pipeline; the front keeps
// taking beats into the four-entry queue until it fills, then raises o_stall.
// Reset (synchronous, active low) empties the front, queue and pipeline.
module quaternion_fast_slerp #(
    parameter int FRAC_BITS = qfs_pkg::FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  qfs_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output qfs_pkg::t_out  o_data
);

    logic            push;
    logic            pop;
    qfs_pkg::t_work  f_item;
    qfs_pkg::t_work  q_item;
    qfs_pkg::t_qstat qst;

    // front part
    qfs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (push),
        .o_item  (f_item),
        .i_qst   (qst)
    );

    // queue between the parts
    qfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (qst)
    );

    // back part
    qfs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_item),
        .i_qst   (qst),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

>>> sv/qfs_checker.sv
// port-level checks for the quaternion slerp block, bound to the top level
module qfs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input qfs_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input qfs_pkg::t_out o_data
);

    // a stalled result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result beat changed under stall");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat shown right after reset");

    // reset empties the front register, so no stall follows it
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    // backpressure only starts after a beat was offered
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("input stall rose with no beat offered");

endmodule

bind quaternion_fast_slerp qfs_checker u_qfs_checker (.*);
